@@ src/splice_info_section_parser_top_defines.svh @@
// Assertion macros shared by the splice information section parser RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef SPLICE_INFO_SECTION_PARSER_TOP_DEFINES_SVH
`define SPLICE_INFO_SECTION_PARSER_TOP_DEFINES_SVH

// Same-cycle implication.
`define SISP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sisp same-cycle check failed");

// Next-cycle implication.
`define SISP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sisp next-cycle check failed");

`endif

@@ src/sisp_pkg.sv @@
// Types and constants of the splice information section parser.
// Used by sisp_out_skid and splice_info_section_parser_top; no dependencies.
package sisp_pkg;

  localparam int CountW    = 13;
  localparam int LenW      = 12;
  localparam int PidW      = 13;
  localparam int PtsW      = 33;
  localparam int EventW    = 32;
  localparam int InDataW   = 8;
  localparam int InUserW   = 14;
  localparam int OutDataW  = 152;
  localparam int OutUserW  = 8;

  localparam logic [CountW-1:0] CountMax       = {CountW{1'b1}};
  localparam logic [CountW-1:0] MinSectionLen  = CountW'(11);
  localparam logic [CountW-1:0] LengthOverhead = CountW'(3);

  localparam logic [7:0] TableIdSpliceInfo = 8'hFC;
  localparam logic [7:0] CmdSpliceInsert   = 8'h05;
  localparam logic [7:0] CmdTimeSignal     = 8'h06;

  // Byte offsets inside the section.
  localparam logic [CountW-1:0] OffTableId    = CountW'(0);
  localparam logic [CountW-1:0] OffLenHi      = CountW'(1);
  localparam logic [CountW-1:0] OffLenLo      = CountW'(2);
  localparam logic [CountW-1:0] OffAdjLead    = CountW'(4);
  localparam logic [CountW-1:0] OffCmd        = CountW'(13);
  localparam logic [CountW-1:0] OffEventLead  = CountW'(13);
  localparam logic [CountW-1:0] OffTsTspec    = CountW'(14);
  localparam logic [CountW-1:0] OffCancel     = CountW'(18);
  localparam logic [CountW-1:0] OffFlags      = CountW'(19);
  localparam logic [CountW-1:0] OffInsTspec   = CountW'(20);
  localparam logic [CountW-1:0] OffDurNoSched = CountW'(20);
  localparam logic [CountW-1:0] OffDurNoTime  = CountW'(21);
  localparam logic [CountW-1:0] OffDurTime    = CountW'(25);

  typedef struct packed {
    logic [PidW-1:0]   source_pid;
    logic [7:0]        command_kind;
    logic [PtsW-1:0]   pts_adjustment;
    logic [EventW-1:0] event_number;
    logic              cancel_flag;
    logic              oon_flag;
    logic              prog_flag;
    logic              splice_immediate;
    logic              time_present;
    logic [PtsW-1:0]   splice_pts;
    logic              duration_present;
    logic [PtsW-1:0]   break_duration;
  } result_t;

endpackage

@@ src/splice_info_section_parser_top.sv @@
// Splice information section parser, top level.
// Depends on sisp_pkg, sisp_out_skid and splice_info_section_parser_top_defines.svh.
//
// Takes one section byte per transfer and sustains one byte per clock while the
// output buffer has space: every byte updates the section registers through one
// capture stage keyed by its byte offset. A section's result enters the output buffer
// with its last byte's transfer, and only if the table id is 0xFC, at least 11 bytes
// arrived and the declared length plus 3 fits in them. A two-entry output buffer lets
// bytes keep flowing while a result waits; the slave side stalls only when both
// entries hold results. Fields that the data stops short of read as zero.
`include "splice_info_section_parser_top_defines.svh"

module splice_info_section_parser_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // data_byte[7:0]
  input  logic [sisp_pkg::InDataW-1:0]    s_axis_tdata,
  // first_byte[0], stream_pid[13:1]
  input  logic [sisp_pkg::InUserW-1:0]    s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // source_pid[12:0], pts_adjustment[45:13], event_number[77:46], cancel_flag[78],
  // oon_flag[79], prog_flag[80], splice_immediate[81], time_present[82],
  // splice_pts[115:83], duration_present[116], break_duration[149:117], zero[151:150]
  output logic [sisp_pkg::OutDataW-1:0]   m_axis_tdata,
  // command_kind[7:0]
  output logic [sisp_pkg::OutUserW-1:0]   m_axis_tuser
);
  import sisp_pkg::*;

  function automatic logic [PtsW-1:0] load_pts(logic [PtsW-1:0] cur, logic [CountW-1:0] idx,
                                               logic [CountW-1:0] lead, logic [7:0] b);
    logic [PtsW-1:0] r;
    r = cur;
    if (idx == lead) r[PtsW-1] = b[0];
    for (int k = 1; k <= 4; k++) begin
      if (idx == lead + CountW'(k)) r[39-8*k -: 8] = b;
    end
    return r;
  endfunction

  function automatic logic [EventW-1:0] load_evt(logic [EventW-1:0] cur,
                                                 logic [CountW-1:0] idx,
                                                 logic [CountW-1:0] lead, logic [7:0] b);
    logic [EventW-1:0] r;
    r = cur;
    for (int k = 1; k <= 4; k++) begin
      if (idx == lead + CountW'(k)) r[39-8*k -: 8] = b;
    end
    return r;
  endfunction

  logic              in_xfer, in_first, res_space, emit;
  logic [7:0]        b;
  logic [CountW-1:0] idx;
  logic              ins, tsg, tflag;

  logic [CountW-1:0] cnt_q, cnt_d, cnt_n;
  logic [LenW-1:0]   len_q, len_d, len_n;
  logic              table_ok_q, table_ok_d, table_ok_n;
  logic [PidW-1:0]   pid_q, pid_d;
  logic [PtsW-1:0]   adj_q, adj_d, adj_n;
  logic [7:0]        cmd_q, cmd_d, cmd_n;
  logic [EventW-1:0] evt_q, evt_d, evt_n;
  logic              cancel_q, cancel_d, cancel_n;
  logic              oon_q, oon_d, oon_n;
  logic              prog_q, prog_d, prog_n;
  logic              dur_q, dur_d, dur_n;
  logic              imm_q, imm_d, imm_n;
  logic              time_flag_q, time_flag_d, time_flag_n;
  logic [PtsW-1:0]   time_q, time_d, time_n;
  logic [PtsW-1:0]   brk_q, brk_d, brk_n;
  result_t           res_new, res_out;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_first      = s_axis_tuser[0];
  assign b             = s_axis_tdata;
  assign s_axis_tready = res_space;
  assign idx           = in_first ? '0 : cnt_q;

  always_comb begin
    cnt_n       = (idx == CountMax) ? idx : idx + CountW'(1);
    len_n       = in_first ? '0 : len_q;
    table_ok_n  = in_first ? 1'b0 : table_ok_q;
    adj_n       = in_first ? '0 : adj_q;
    cmd_n       = in_first ? '0 : cmd_q;
    evt_n       = in_first ? '0 : evt_q;
    cancel_n    = in_first ? 1'b0 : cancel_q;
    oon_n       = in_first ? 1'b0 : oon_q;
    prog_n      = in_first ? 1'b0 : prog_q;
    dur_n       = in_first ? 1'b0 : dur_q;
    imm_n       = in_first ? 1'b0 : imm_q;
    time_flag_n = in_first ? 1'b0 : time_flag_q;
    time_n      = in_first ? '0 : time_q;
    brk_n       = in_first ? '0 : brk_q;
    ins         = cmd_n == CmdSpliceInsert;
    tsg         = cmd_n == CmdTimeSignal;
    tflag       = 1'b0;

    if (idx == OffTableId) table_ok_n = b == TableIdSpliceInfo;
    if (idx == OffLenHi) len_n[LenW-1:8] = b[3:0];
    if (idx == OffLenLo) len_n[7:0] = b;
    adj_n = load_pts(adj_n, idx, OffAdjLead, b);
    if (idx == OffCmd) cmd_n = b;

    if (ins) begin
      evt_n = load_evt(evt_n, idx, OffEventLead, b);
      if (idx == OffCancel) cancel_n = b[7];
      if (!cancel_n) begin
        if (idx == OffFlags) {oon_n, prog_n, dur_n, imm_n} = b[7:4];
        if (prog_n && !imm_n) begin
          tflag = (idx == OffInsTspec) ? b[7] : time_flag_n;
          if (idx == OffInsTspec) time_flag_n = b[7];
          if (tflag) time_n = load_pts(time_n, idx, OffInsTspec, b);
          if (dur_n) brk_n = load_pts(brk_n, idx, tflag ? OffDurTime : OffDurNoTime, b);
        end else if (dur_n) begin
          brk_n = load_pts(brk_n, idx, OffDurNoSched, b);
        end
      end
    end else if (tsg) begin
      tflag = (idx == OffTsTspec) ? b[7] : time_flag_n;
      if (idx == OffTsTspec) time_flag_n = b[7];
      if (tflag) time_n = load_pts(time_n, idx, OffTsTspec, b);
    end

    emit = in_xfer && s_axis_tlast && table_ok_n && (cnt_n >= MinSectionLen) &&
           (CountW'(len_n) + LengthOverhead <= cnt_n);
  end

  always_comb begin
    res_new.source_pid       = pid_d;
    res_new.command_kind     = cmd_n;
    res_new.pts_adjustment   = adj_n;
    res_new.event_number     = evt_n;
    res_new.cancel_flag      = cancel_n;
    res_new.oon_flag         = oon_n;
    res_new.prog_flag        = prog_n;
    res_new.splice_immediate = imm_n;
    res_new.time_present     = time_flag_n;
    res_new.splice_pts       = time_n;
    res_new.duration_present = dur_n;
    res_new.break_duration   = brk_n;
  end

  always_comb begin
    pid_d = (in_xfer && in_first) ? s_axis_tuser[InUserW-1:1] : pid_q;
    if (!in_xfer) begin
      cnt_d = cnt_q; len_d = len_q; table_ok_d = table_ok_q; adj_d = adj_q;
      cmd_d = cmd_q; evt_d = evt_q; cancel_d = cancel_q; oon_d = oon_q;
      prog_d = prog_q; dur_d = dur_q; imm_d = imm_q; time_flag_d = time_flag_q;
      time_d = time_q; brk_d = brk_q;
    end else if (s_axis_tlast) begin
      cnt_d = '0; len_d = '0; table_ok_d = 1'b0; adj_d = '0;
      cmd_d = '0; evt_d = '0; cancel_d = 1'b0; oon_d = 1'b0;
      prog_d = 1'b0; dur_d = 1'b0; imm_d = 1'b0; time_flag_d = 1'b0;
      time_d = '0; brk_d = '0;
    end else begin
      cnt_d = cnt_n; len_d = len_n; table_ok_d = table_ok_n; adj_d = adj_n;
      cmd_d = cmd_n; evt_d = evt_n; cancel_d = cancel_n; oon_d = oon_n;
      prog_d = prog_n; dur_d = dur_n; imm_d = imm_n; time_flag_d = time_flag_n;
      time_d = time_n; brk_d = brk_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; len_q <= '0; table_ok_q <= 1'b0; pid_q <= '0; adj_q <= '0;
      cmd_q <= '0; evt_q <= '0; cancel_q <= 1'b0; oon_q <= 1'b0; prog_q <= 1'b0;
      dur_q <= 1'b0; imm_q <= 1'b0; time_flag_q <= 1'b0; time_q <= '0; brk_q <= '0;
    end else begin
      cnt_q <= cnt_d; len_q <= len_d; table_ok_q <= table_ok_d; pid_q <= pid_d;
      adj_q <= adj_d; cmd_q <= cmd_d; evt_q <= evt_d; cancel_q <= cancel_d;
      oon_q <= oon_d; prog_q <= prog_d; dur_q <= dur_d; imm_q <= imm_d;
      time_flag_q <= time_flag_d; time_q <= time_d; brk_q <= brk_d;
    end
  end

  sisp_out_skid u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (emit),
    .res_i     (res_new),
    .space_o   (res_space),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res_out)
  );

  assign m_axis_tuser = res_out.command_kind;
  assign m_axis_tdata = {2'b00, res_out.break_duration, res_out.duration_present,
                         res_out.splice_pts, res_out.time_present, res_out.splice_immediate,
                         res_out.prog_flag, res_out.oon_flag, res_out.cancel_flag,
                         res_out.event_number, res_out.pts_adjustment, res_out.source_pid};

  `SISP_ASSERT_IMPL(a_cancel_masks_flags, cancel_q, !(oon_q || prog_q || dur_q || imm_q))
  `SISP_ASSERT_IMPL(a_time_needs_cmd, time_flag_q,
                    (cmd_q == CmdSpliceInsert) || (cmd_q == CmdTimeSignal))
  `SISP_ASSERT_NEXT(a_last_clears, in_xfer && s_axis_tlast, (cnt_q == '0) && !table_ok_q)

endmodule

@@ src/sisp_out_skid.sv @@
// Two-entry output buffer (output register plus skid register) for results.
// Depends on sisp_pkg and splice_info_section_parser_top_defines.svh.
`include "splice_info_section_parser_top_defines.svh"

module sisp_out_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sisp_pkg::result_t res_i,
  output logic              space_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output sisp_pkg::result_t res_o
);
  import sisp_pkg::*;

  logic    out_v_q, out_v_d;
  logic    skid_v_q, skid_v_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop       = out_v_q && m_ready_i;
  assign space_o   = !skid_v_q;
  assign m_valid_o = out_v_q;
  assign res_o     = out_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (pop || !out_v_q) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = push_i;
        out_d   = res_i;
      end
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `SISP_ASSERT_IMPL(a_skid_needs_out, skid_v_q, out_v_q)
  `SISP_ASSERT_NEXT(a_skid_kept, skid_v_q && !pop, skid_v_q)
  `SISP_ASSERT_NEXT(a_stall_to_skid, push_i && out_v_q && !m_ready_i, skid_v_q)

endmodule

@@ dv/tb_splice_info_section_parser_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for splice_info_section_parser_top: directed sections, then random ones.
// Holds a bit-serial parse predictor; depends on sisp_pkg and the RTL only.
module tb_splice_info_section_parser_top;
  import sisp_pkg::*;

  typedef enum logic [4:0] {
    P_TBL_ID, P_HDR_FLAGS, P_SEC_LEN, P_RSVD15, P_ADJUST, P_RSVD32, P_COMMAND,
    P_EVENT, P_CANCEL, P_RSVD_C, P_INS_FLAGS, P_RSVD_F, P_TIME_SPEC, P_RSVD_T,
    P_PTS, P_RSVD_NT, P_RSVD_D, P_DURATION, P_END
  } parse_phase_e;

  typedef enum {CHK_MODEL, CHK_GIVEN, CHK_NONE} check_e;

  typedef struct {
    logic [7:0]  tbl_id;
    int          sec_len;
    logic [32:0] adj;
    logic [7:0]  cmd;
    logic [31:0] evt_num;
    bit          cancel;
    bit          oon;
    bit          prog;
    bit          dur;
    bit          imm;
    bit          tspec;
    logic [32:0] pts;
    logic [32:0] brk;
  } section_t;

  typedef struct {
    check_e      how;
    logic [12:0] pid;
    bit          first;
    bit          last;
    int          cut;
    int          extra;
    section_t    s;
    result_t     want;
  } row_t;

  localparam logic [32:0] Max33 = 33'h1_FFFF_FFFF;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [InUserW-1:0]  s_axis_tuser = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  splice_info_section_parser_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int failures = 0;
  int bytes_sent = 0;
  result_t section_results_q[$];

  // Parse state of the predictor; source_pid of sect_fields is the latched pid.
  logic [12:0]  sect_count = '0;
  logic [11:0]  sect_declared = '0;
  parse_phase_e sect_phase = P_TBL_ID;
  logic [32:0]  field_acc = '0;
  logic [5:0]   field_left = '0;
  bit           tbl_ok = 1'b0;
  result_t      sect_fields = '0;

  bit         sect_bits[$];
  logic [7:0] sect_bytes[$];

  function automatic void clear_section();
    logic [12:0] pid;
    pid = sect_fields.source_pid;
    sect_count = '0;
    sect_declared = '0;
    sect_phase = P_TBL_ID;
    field_acc = '0;
    field_left = '0;
    tbl_ok = 1'b0;
    sect_fields = '0;
    sect_fields.source_pid = pid;
  endfunction

  function automatic logic [5:0] phase_bits(parse_phase_e p);
    case (p)
      P_TBL_ID, P_COMMAND: return 6'd8;
      P_HDR_FLAGS, P_INS_FLAGS, P_RSVD_F: return 6'd4;
      P_SEC_LEN: return 6'd12;
      P_RSVD15: return 6'd15;
      P_ADJUST, P_PTS, P_DURATION: return 6'd33;
      P_RSVD32, P_EVENT: return 6'd32;
      P_CANCEL, P_TIME_SPEC: return 6'd1;
      P_RSVD_C, P_RSVD_NT, P_RSVD_D: return 6'd7;
      P_RSVD_T: return 6'd6;
      default: return 6'd0;
    endcase
  endfunction

  function automatic parse_phase_e after_splice_time();
    if (sect_fields.command_kind == CmdSpliceInsert && sect_fields.duration_present)
      return P_RSVD_D;
    return P_END;
  endfunction

  function automatic void close_field();
    parse_phase_e nxt;
    nxt = P_END;
    case (sect_phase)
      P_TBL_ID: begin
        tbl_ok = (field_acc == 33'(TableIdSpliceInfo));
        nxt = P_HDR_FLAGS;
      end
      P_HDR_FLAGS: nxt = P_SEC_LEN;
      P_SEC_LEN: begin
        sect_declared = field_acc[11:0];
        nxt = P_RSVD15;
      end
      P_RSVD15: nxt = P_ADJUST;
      P_ADJUST: begin
        sect_fields.pts_adjustment = field_acc;
        nxt = P_RSVD32;
      end
      P_RSVD32: nxt = P_COMMAND;
      P_COMMAND: begin
        sect_fields.command_kind = field_acc[7:0];
        if (field_acc[7:0] == CmdSpliceInsert) nxt = P_EVENT;
        else if (field_acc[7:0] == CmdTimeSignal) nxt = P_TIME_SPEC;
      end
      P_EVENT: begin
        sect_fields.event_number = field_acc[31:0];
        nxt = P_CANCEL;
      end
      P_CANCEL: begin
        sect_fields.cancel_flag = field_acc[0];
        nxt = P_RSVD_C;
      end
      P_RSVD_C: nxt = sect_fields.cancel_flag ? P_END : P_INS_FLAGS;
      P_INS_FLAGS: begin
        sect_fields.oon_flag = field_acc[3];
        sect_fields.prog_flag = field_acc[2];
        sect_fields.duration_present = field_acc[1];
        sect_fields.splice_immediate = field_acc[0];
        nxt = P_RSVD_F;
      end
      P_RSVD_F: begin
        if (sect_fields.prog_flag && !sect_fields.splice_immediate) nxt = P_TIME_SPEC;
        else nxt = after_splice_time();
      end
      P_TIME_SPEC: begin
        if (field_acc[0]) begin
          sect_fields.time_present = 1'b1;
          nxt = P_RSVD_T;
        end else begin
          nxt = (sect_fields.command_kind == CmdSpliceInsert) ? P_RSVD_NT : P_END;
        end
      end
      P_RSVD_T: nxt = P_PTS;
      P_PTS: begin
        sect_fields.splice_pts = field_acc;
        nxt = after_splice_time();
      end
      P_RSVD_NT: nxt = after_splice_time();
      P_RSVD_D: nxt = P_DURATION;
      P_DURATION: sect_fields.break_duration = field_acc;
      default: nxt = P_END;
    endcase
    sect_phase = nxt;
    field_acc = '0;
    field_left = '0;
  endfunction

  function automatic void parse_bit(bit b);
    if (sect_phase == P_END) return;
    if (field_left == 0) begin
      field_left = phase_bits(sect_phase);
      field_acc = '0;
    end
    field_acc = {field_acc[31:0], b};
    field_left--;
    if (field_left == 0) close_field();
  endfunction

  function automatic void parse_section_byte(input logic [7:0] d, input bit first,
                                             input bit last, input logic [12:0] pid,
                                             output bit emit, output result_t res);
    emit = 1'b0;
    res = '0;
    if (first) begin
      clear_section();
      sect_fields.source_pid = pid;
    end
    if (sect_count != CountMax) sect_count++;
    for (int i = 7; i >= 0; i--) parse_bit(d[i]);
    if (last) begin
      while (sect_phase != P_END) parse_bit(1'b0);
      if (tbl_ok && sect_count >= MinSectionLen &&
          {1'b0, sect_declared} + LengthOverhead <= sect_count) begin
        emit = 1'b1;
        res = sect_fields;
      end
      clear_section();
    end
  endfunction

  function automatic void add_bits(input logic [63:0] v, input int w);
    for (int i = w - 1; i >= 0; i--) sect_bits.push_back(v[i]);
  endfunction

  function automatic void add_splice_time(input bit spec, input logic [32:0] pts);
    add_bits(spec, 1);
    if (spec) begin
      add_bits($urandom, 6);
      add_bits(pts, 33);
    end else begin
      add_bits($urandom, 7);
    end
  endfunction

  function automatic void build_section(input section_t s);
    logic [11:0] len;
    sect_bits.delete();
    sect_bytes.delete();
    add_bits(s.tbl_id, 8);
    add_bits($urandom, 4);
    add_bits(0, 12);
    add_bits($urandom, 15);
    add_bits(s.adj, 33);
    add_bits($urandom, 32);
    add_bits(s.cmd, 8);
    if (s.cmd == CmdSpliceInsert) begin
      add_bits(s.evt_num, 32);
      add_bits(s.cancel, 1);
      add_bits($urandom, 7);
      if (!s.cancel) begin
        add_bits({s.oon, s.prog, s.dur, s.imm}, 4);
        add_bits($urandom, 4);
        if (s.prog && !s.imm) add_splice_time(s.tspec, s.pts);
        if (s.dur) begin
          add_bits($urandom, 7);
          add_bits(s.brk, 33);
        end
        add_bits($urandom, 32);
      end
    end else if (s.cmd == CmdTimeSignal) begin
      add_splice_time(s.tspec, s.pts);
    end
    add_bits($urandom, 32);
    while (sect_bits.size() % 8 != 0) sect_bits.push_back(1'b0);
    for (int i = 0; i < sect_bits.size(); i += 8) begin
      logic [7:0] b;
      for (int k = 0; k < 8; k++) b[7-k] = sect_bits[i+k];
      sect_bytes.push_back(b);
    end
    len = (s.sec_len < 0) ? 12'(sect_bytes.size() - 3) : 12'(s.sec_len);
    sect_bytes[1] = {sect_bytes[1][7:4], len[11:8]};
    sect_bytes[2] = len[7:0];
  endfunction

  function automatic logic [32:0] rand33();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return Max33;
    return {1'($urandom), 32'($urandom)};
  endfunction

  function automatic void log_failure(string what);
    failures++;
    if (failures <= 10) $display("%0t: %s", $time, what);
  endfunction

  task automatic send_byte(input logic [7:0] d, input bit first, input bit last,
                           input logic [12:0] pid, input check_e how, input result_t want);
    bit emit;
    result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= {pid, first};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    parse_section_byte(d, first, last, pid, emit, res);
    case (how)
      CHK_MODEL: if (emit) section_results_q.push_back(res);
      CHK_GIVEN: if (last) section_results_q.push_back(want);
      default: ;
    endcase
  endtask

  task automatic send_section(input row_t r);
    int n;
    build_section(r.s);
    if (r.cut > 0) while (sect_bytes.size() > r.cut) void'(sect_bytes.pop_back());
    repeat (r.extra) sect_bytes.push_back(8'($urandom));
    n = sect_bytes.size();
    for (int i = 0; i < n; i++)
      send_byte(sect_bytes[i], r.first && i == 0, r.last && i == n - 1,
                (i == 0) ? r.pid : 13'($urandom), r.how, r.want);
  endtask

  row_t dir_rows[0:19] = '{
    '{CHK_GIVEN, 13'h1ABC, 0, 1, 0, 0,
      '{TableIdSpliceInfo, -1, Max33, 8'h00, 32'h0, 0, 0, 0, 0, 0, 0, 33'h0, 33'h0},
      '{13'h0, 8'h00, Max33, 32'h0, 0, 0, 0, 0, 0, 33'h0, 0, 33'h0}},
    '{CHK_GIVEN, 13'h1FFF, 1, 1, 0, 0,
      '{TableIdSpliceInfo, -1, Max33, CmdSpliceInsert, 32'hFFFF_FFFF, 0, 1, 1, 1, 0, 1,
        Max33, Max33},
      '{13'h1FFF, CmdSpliceInsert, Max33, 32'hFFFF_FFFF, 0, 1, 1, 0, 1, Max33, 1, Max33}},
    '{CHK_MODEL, 13'h0000, 1, 1, 0, 0,
      '{TableIdSpliceInfo, -1, 33'h0, CmdSpliceInsert, 32'h0, 0, 0, 0, 0, 0, 0, 33'h0, 33'h0},
      '0},
    '{CHK_MODEL, 13'h0155, 1, 1, 0, 0,
      '{TableIdSpliceInfo, -1, 33'h0_1234_5678, CmdSpliceInsert, 32'h1234_5678, 1, 1, 1, 1, 1,
        1, Max33, Max33}, '0},
    '{CHK_MODEL, 13'h0A0A, 1, 1, 0, 0,
      '{TableIdSpliceInfo, -1, 33'h1_0000_0000, CmdSpliceInsert, 32'h8000_0001, 0, 0, 1, 0, 1,
        1, Max33, 33'h0}, '0},
    '{CHK_MODEL, 13'h1555, 1, 1, 0, 0,
      '{TableIdSpliceInfo, -1, 33'h0_0000_0001, CmdSpliceInsert, 32'h0000_00FF, 0, 1, 0, 1, 0,
        1, Max33, 33'h0_0001_5F90}, '0},
    '{CHK_MODEL, 13'h0001, 1, 1, 0, 0,
      '{TableIdSpliceInfo, -1, 33'h1_5555_5555, CmdSpliceInsert, 32'hA5A5_5A5A, 0, 0, 1, 1, 0,
        0, Max33, 33'h1_2222_3333}, '0},
    '{CHK_MODEL, 13'h1000, 1, 1, 0, 0,
      '{TableIdSpliceInfo, -1, 33'h0_AAAA_AAAA, CmdTimeSignal, 32'h0, 0, 0, 0, 0, 0, 1,
        33'h1_2345_6789, 33'h0}, '0},
    '{CHK_MODEL, 13'h0FFF, 1, 1, 0, 0,
      '{TableIdSpliceInfo, -1, Max33, CmdTimeSignal, 32'h0, 0, 0, 0, 0, 0, 0, Max33, 33'h0},
      '0},
    '{CHK_MODEL, 13'h0123, 1, 1, 0, 0,
      '{TableIdSpliceInfo, -1, 33'h0_0F0F_0F0F, 8'hFF, 32'h0, 0, 0, 0, 0, 0, 0, 33'h0, 33'h0},
      '0},
    '{CHK_NONE, 13'h0234, 1, 1, 0, 0,
      '{8'hFB, -1, Max33, CmdTimeSignal, 32'h0, 0, 0, 0, 0, 0, 1, Max33, 33'h0}, '0},
    '{CHK_NONE, 13'h0345, 1, 1, 10, 0,
      '{TableIdSpliceInfo, 7, Max33, CmdTimeSignal, 32'h0, 0, 0, 0, 0, 0, 1, Max33, 33'h0},
      '0},
    '{CHK_MODEL, 13'h0456, 1, 1, 11, 0,
      '{TableIdSpliceInfo, 8, Max33, CmdTimeSignal, 32'h0, 0, 0, 0, 0, 0, 1, Max33, 33'h0},
      '0},
    '{CHK_NONE, 13'h0567, 1, 1, 0, 0,
      '{TableIdSpliceInfo, 4095, Max33, CmdSpliceInsert, 32'h1, 0, 1, 1, 1, 0, 1, Max33,
        Max33}, '0},
    '{CHK_MODEL, 13'h0678, 1, 1, 0, 0,
      '{TableIdSpliceInfo, 0, 33'h0_0000_0100, CmdSpliceInsert, 32'h2, 0, 1, 1, 0, 0, 1,
        33'h0_0000_0200, 33'h0}, '0},
    '{CHK_NONE, 13'h0789, 1, 1, 1, 0,
      '{TableIdSpliceInfo, -1, Max33, CmdTimeSignal, 32'h0, 0, 0, 0, 0, 0, 1, Max33, 33'h0},
      '0},
    '{CHK_MODEL, 13'h089A, 1, 0, 9, 0,
      '{TableIdSpliceInfo, -1, Max33, CmdSpliceInsert, 32'h3, 0, 1, 1, 1, 0, 1, Max33, Max33},
      '0},
    '{CHK_MODEL, 13'h0AAA, 1, 1, 0, 0,
      '{TableIdSpliceInfo, -1, 33'h1_0101_0101, CmdSpliceInsert, 32'h4, 0, 1, 1, 0, 0, 1,
        33'h0_7654_3210, 33'h0}, '0},
    '{CHK_MODEL, 13'h1555, 0, 1, 0, 0,
      '{TableIdSpliceInfo, -1, 33'h0_0202_0202, CmdTimeSignal, 32'h0, 0, 0, 0, 0, 0, 1,
        33'h0_0000_0005, 33'h0}, '0},
    '{CHK_MODEL, 13'h0BCD, 1, 1, 16, 0,
      '{TableIdSpliceInfo, 12, Max33, CmdSpliceInsert, 32'hDEAD_BEEF, 0, 1, 1, 1, 0, 1,
        Max33, Max33}, '0}
  };

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    string   bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.source_pid       = m_axis_tdata[12:0];
      got.command_kind     = m_axis_tuser;
      got.pts_adjustment   = m_axis_tdata[45:13];
      got.event_number     = m_axis_tdata[77:46];
      got.cancel_flag      = m_axis_tdata[78];
      got.oon_flag         = m_axis_tdata[79];
      got.prog_flag        = m_axis_tdata[80];
      got.splice_immediate = m_axis_tdata[81];
      got.time_present     = m_axis_tdata[82];
      got.splice_pts       = m_axis_tdata[115:83];
      got.duration_present = m_axis_tdata[116];
      got.break_duration   = m_axis_tdata[149:117];
      if (section_results_q.size() == 0) begin
        log_failure($sformatf("unexpected section result %p", got));
      end else begin
        want = section_results_q.pop_front();
        bad = "";
        if (got.source_pid != want.source_pid) bad = {bad, " source_pid"};
        if (got.command_kind != want.command_kind) bad = {bad, " command_kind"};
        if (got.pts_adjustment != want.pts_adjustment) bad = {bad, " pts_adjustment"};
        if (got.event_number != want.event_number) bad = {bad, " event_number"};
        if (got.cancel_flag != want.cancel_flag) bad = {bad, " cancel_flag"};
        if (got.oon_flag != want.oon_flag) bad = {bad, " oon_flag"};
        if (got.prog_flag != want.prog_flag) bad = {bad, " prog_flag"};
        if (got.splice_immediate != want.splice_immediate) bad = {bad, " splice_immediate"};
        if (got.time_present != want.time_present) bad = {bad, " time_present"};
        if (got.splice_pts != want.splice_pts) bad = {bad, " splice_pts"};
        if (got.duration_present != want.duration_present) bad = {bad, " duration_present"};
        if (got.break_duration != want.break_duration) bad = {bad, " break_duration"};
        if (bad != "")
          log_failure($sformatf("mismatch in%s: expected %p, actual %p", bad, want, got));
      end
    end
  end

  initial begin
    row_t r;
    int   base;
    int   stage;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    src_idle_pct = 27;
    sink_idle_pct = 67;
    foreach (dir_rows[i]) send_section(dir_rows[i]);

    base = bytes_sent;
    while (bytes_sent - base < 1320) begin
      stage = (bytes_sent - base) / 440;
      src_idle_pct  = (stage == 0) ? 27 : (stage == 1) ? 67 : 0;
      sink_idle_pct = (stage == 0) ? 67 : (stage == 1) ? 27 : 0;
      r.how = CHK_MODEL;
      r.pid = ($urandom_range(9) == 0) ? {13{1'($urandom)}} : 13'($urandom);
      r.first = ($urandom_range(99) < 92);
      r.last = ($urandom_range(99) < 94);
      r.cut = ($urandom_range(99) < 85) ? 0 : $urandom_range(30, 1);
      r.extra = ($urandom_range(99) < 85) ? 0 : $urandom_range(6, 1);
      r.want = '0;
      r.s.tbl_id = ($urandom_range(99) < 92) ? TableIdSpliceInfo : 8'($urandom);
      case ($urandom_range(99) / 5)
        0: r.s.sec_len = $urandom_range(4095);
        1: r.s.sec_len = $urandom_range(40);
        default: r.s.sec_len = -1;
      endcase
      case ($urandom_range(99) / 20)
        0, 1: r.s.cmd = CmdSpliceInsert;
        2: r.s.cmd = CmdTimeSignal;
        3: r.s.cmd = ($urandom_range(1) == 0) ? CmdTimeSignal : CmdSpliceInsert;
        default: r.s.cmd = 8'($urandom);
      endcase
      r.s.adj = rand33();
      r.s.evt_num = 32'(rand33());
      r.s.cancel = ($urandom_range(99) < 15);
      r.s.oon = 1'($urandom);
      r.s.prog = 1'($urandom);
      r.s.dur = 1'($urandom);
      r.s.imm = 1'($urandom);
      r.s.tspec = 1'($urandom);
      r.s.pts = rand33();
      r.s.brk = rand33();
      send_section(r);
    end
    s_axis_tvalid <= 1'b0;

    while (section_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
